>>> hw/rtl/ecma_pkg.sv
// ============================================================================
// ecma_pkg: shared types and constants for the edge-conv max aggregator
// Field widths, action codes and default parameter values.
// ============================================================================
package ecma_pkg;

  localparam int unsigned EmbWidthDef     = 8;
  localparam int unsigned NodeCapacityDef = 1024;
  localparam int unsigned WordBitsDef     = 16;
  localparam int unsigned FractionBitsDef = 10;

  localparam int unsigned ActionW = 3;
  localparam int unsigned NodeW   = 10;
  localparam int unsigned RowW    = 3;
  localparam int unsigned ColW    = 4;
  localparam int unsigned ValueW  = 16;

  typedef enum logic [ActionW-1:0] {
    ActLoadWeight = 3'd0,
    ActLoadBias   = 3'd1,
    ActLoadNode   = 3'd2,
    ActLoadTarget = 3'd3,
    ActEdge       = 3'd4,
    ActEmpty      = 3'd5
  } action_e;

  typedef struct packed {
    logic [ActionW-1:0]      action;
    logic [NodeW-1:0]        node_index;
    logic [RowW-1:0]         row;
    logic [ColW-1:0]         column;
    logic signed [ValueW-1:0] value;
    logic                    first_edge;
    logic                    last_edge;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0]         target_node;
    logic [RowW-1:0]          element;
    logic signed [ValueW-1:0] message_value;
    logic                     last;
  } out_item_t;

endpackage

>>> hw/rtl/ecma_stream_if.sv
// ============================================================================
// ecma_stream_if: valid/ready channel
// Carries one payload of type PAYLOAD_T per transfer.
// ============================================================================
interface ecma_stream_if #(
  parameter type PAYLOAD_T = ecma_pkg::in_item_t
);
  logic     valid;
  logic     ready;
  PAYLOAD_T payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/edge_conv_max_aggregate_core.sv
// ============================================================================
// edge_conv_max_aggregate_core: edge-conv message passing, max aggregation
// One processing element; one shared multiply-accumulate unit.
// ============================================================================
// Usage:
//   in_if  (sink):   load items (weight, bias, node, target), edge items and
//                    empty-node items, one per transfer.
//   out_if (source): message elements, EMB_WIDTH transfers per message, last
//                    set on the final element.
// Flow:
//   An edge runs the shared MAC over every output row and every feature, after
//   one node memory read per element while the features are gathered. The
//   block takes no new item until the edge is done. A message or empty node
//   then drains EMB_WIDTH elements, one per cycle when the sink is ready.
// Reset:
//   rst_ni low clears control state, current target and the running maximum
//   (most negative value). Stores are undefined until written.
// Stall:
//   While a message element waits for out_if.ready the block takes no new
//   item; the element register holds steady until transferred.
// ============================================================================
module edge_conv_max_aggregate_core #(
  parameter int unsigned EMB_WIDTH     = ecma_pkg::EmbWidthDef,
  parameter int unsigned NODE_CAPACITY = ecma_pkg::NodeCapacityDef,
  parameter int unsigned WORD_BITS     = ecma_pkg::WordBitsDef,
  parameter int unsigned FRACTION_BITS = ecma_pkg::FractionBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ecma_stream_if.sink   in_if,
  ecma_stream_if.source out_if
);

  localparam int unsigned FeatCount = 2 * EMB_WIDTH;
  localparam int unsigned EW  = (EMB_WIDTH > 1) ? $clog2(EMB_WIDTH) : 1;
  localparam int unsigned FW  = $clog2(FeatCount);
  localparam int unsigned NW  = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
  localparam int unsigned NAW = NW + EW;
  localparam int unsigned WAW = $clog2(EMB_WIDTH*FeatCount);
  localparam int unsigned PW  = 2 * WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    StIdle, StGather, StMac, StBias, StEmit
  } state_e;

  // storage
  word_t weight_mem [EMB_WIDTH*FeatCount];
  word_t bias_q     [EMB_WIDTH];
  word_t node_mem   [EMB_WIDTH*NODE_CAPACITY];
  word_t target_q   [EMB_WIDTH];
  word_t feat_q     [FeatCount];
  word_t max_q      [EMB_WIDTH];
  word_t emit_q     [EMB_WIDTH];

  state_e state_q;
  logic [ecma_pkg::NodeW-1:0] cur_target_q, out_node_q;
  logic [ecma_pkg::NodeW-1:0] cur_neighbor_q;
  logic [EW:0] row_q;   // counts to EMB_WIDTH
  logic [FW:0] col_q;   // counts to FeatCount-1
  logic        last_q, oob_q, rd_valid_q;
  logic [EW-1:0] rd_idx_q;
  word_t node_rd_q, weight_rd_q, acc_q;
  logic        out_valid_q;
  logic [EW:0] out_idx_q;

  localparam word_t MinWord = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

  ecma_pkg::in_item_t it;
  assign it = in_if.payload;

  word_t in_val;
  assign in_val = word_t'(it.value);

  logic in_fire;
  assign in_if.ready = (state_q == StIdle) && !out_valid_q;
  assign in_fire = in_if.valid && in_if.ready;

  // writes into memories
  always_ff @(posedge clk_i) begin
    if (in_fire && it.action == ecma_pkg::ActLoadWeight && 32'(it.row) < EMB_WIDTH
        && 32'(it.column) < FeatCount) begin
      weight_mem[WAW'(32'(it.row) * FeatCount + 32'(it.column))] <= in_val;
    end
    if (in_fire && it.action == ecma_pkg::ActLoadNode && 32'(it.row) < EMB_WIDTH
        && 32'(it.node_index) < NODE_CAPACITY) begin
      node_mem[NAW'(32'(it.node_index) * EMB_WIDTH + 32'(it.row))] <= in_val;
    end
  end

  // memory reads, registered
  logic [NAW-1:0] node_addr;
  logic [WAW-1:0] w_addr;
  logic [EW:0]  rd_row;
  logic [FW:0]  rd_col;
  always_comb begin
    node_addr = NAW'(32'(cur_neighbor_q) * EMB_WIDTH + 32'(row_q[EW-1:0]));
    // prefetch the next weight for the MAC
    rd_row = row_q;
    rd_col = col_q;
    if (state_q == StGather || state_q == StBias) begin
      rd_col = '0;
      if (state_q == StBias) rd_row = row_q + 1'b1;
      else rd_row = '0;
    end else begin
      rd_col = col_q + 1'b1;
    end
    w_addr = WAW'(32'(rd_row[EW-1:0]) * FeatCount + 32'(rd_col[FW-1:0]));
  end

  always_ff @(posedge clk_i) begin
    node_rd_q   <= node_mem[node_addr];
    weight_rd_q <= weight_mem[w_addr];
  end

  // shared multiply, floor shift (arithmetic shift is floor)
  logic signed [PW-1:0] prod;
  word_t prod_sh, mac_sum;
  assign prod    = PW'(feat_q[col_q[FW-1:0]]) * PW'(weight_rd_q);
  assign prod_sh = word_t'(prod >>> FRACTION_BITS);
  assign mac_sum = acc_q + prod_sh;

  word_t biased;
  assign biased = acc_q + bias_q[row_q[EW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cur_target_q <= '0;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      row_q        <= '0;
      col_q        <= '0;
      rd_valid_q   <= 1'b0;
      for (int k = 0; k < EMB_WIDTH; k++) max_q[k] <= MinWord;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            case (it.action)
              ecma_pkg::ActLoadBias: begin
                if (32'(it.row) < EMB_WIDTH) bias_q[it.row[EW-1:0]] <= in_val;
              end
              ecma_pkg::ActLoadTarget: begin
                cur_target_q <= it.node_index;
                if (32'(it.row) < EMB_WIDTH) target_q[it.row[EW-1:0]] <= in_val;
              end
              ecma_pkg::ActEdge: begin
                if (it.first_edge)
                  for (int k = 0; k < EMB_WIDTH; k++) max_q[k] <= MinWord;
                cur_neighbor_q <= it.node_index;
                oob_q      <= !(32'(it.node_index) < NODE_CAPACITY);
                last_q     <= it.last_edge;
                row_q      <= '0;
                rd_valid_q <= 1'b0;
                state_q    <= StGather;
              end
              ecma_pkg::ActEmpty: begin
                for (int k = 0; k < EMB_WIDTH; k++) emit_q[k] <= MinWord;
                out_node_q  <= it.node_index;
                out_idx_q   <= '0;
                out_valid_q <= 1'b1;
                state_q     <= StEmit;
              end
              default: ;
            endcase
          end
        end
        StGather: begin
          // row_q walks the address; the read data follows in the next cycle
          rd_valid_q <= 1'b1;
          rd_idx_q   <= row_q[EW-1:0];
          if (rd_valid_q) begin
            feat_q[FW'(rd_idx_q)] <= target_q[rd_idx_q];
            feat_q[FW'(32'(rd_idx_q) + EMB_WIDTH)] <=
              (oob_q ? word_t'(0) : node_rd_q) - target_q[rd_idx_q];
          end
          if (32'(row_q) < EMB_WIDTH) row_q <= row_q + 1'b1;
          if (rd_valid_q && 32'(rd_idx_q) == EMB_WIDTH - 1) begin
            row_q   <= '0;
            col_q   <= '0;
            acc_q   <= '0;
            state_q <= StMac;
          end
        end
        StMac: begin
          acc_q <= mac_sum;
          if (32'(col_q) == FeatCount - 1) state_q <= StBias;
          else col_q <= col_q + 1'b1;
        end
        StBias: begin
          acc_q <= '0;
          col_q <= '0;
          if (32'(row_q) == EMB_WIDTH - 1 && last_q) begin
            // final row folds straight into the message
            for (int k = 0; k < EMB_WIDTH; k++) begin
              emit_q[k] <= (k == 32'(row_q) && biased > max_q[k]) ? biased : max_q[k];
              max_q[k]  <= MinWord;
            end
            out_node_q  <= cur_target_q;
            out_idx_q   <= '0;
            out_valid_q <= 1'b1;
            state_q     <= StEmit;
          end else begin
            if (biased > max_q[row_q[EW-1:0]]) max_q[row_q[EW-1:0]] <= biased;
            if (32'(row_q) == EMB_WIDTH - 1) begin
              state_q <= StIdle;
            end else begin
              row_q   <= row_q + 1'b1;
              state_q <= StMac;
            end
          end
        end
        StEmit: begin
          if (out_if.ready) begin
            if (32'(out_idx_q) == EMB_WIDTH - 1) begin
              out_valid_q <= 1'b0;
              state_q     <= StIdle;
            end else begin
              out_idx_q <= out_idx_q + 1'b1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_if.valid = out_valid_q;
  always_comb begin
    out_if.payload               = '0;
    out_if.payload.target_node   = out_node_q;
    out_if.payload.element       = ecma_pkg::RowW'(out_idx_q);
    out_if.payload.message_value = ecma_pkg::ValueW'(emit_q[out_idx_q[EW-1:0]]);
    out_if.payload.last          = (32'(out_idx_q) == EMB_WIDTH - 1);
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> (state_q == StIdle)) else $error("ready outside idle");
  a_valid_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == StEmit)) else $error("output valid outside emit");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |=> $stable(out_idx_q)) else $error("index moved");
  a_mac_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMac) |-> (32'(col_q) < FeatCount)) else $error("column overrun");
`endif

endmodule
